// ===== hdl/qma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qma_pkg
// Types and constants shared by the qualified moving-average filter: the
// input and result word layouts, status codes and register indexes.
// ----------------------------------------------------------------------------
package qma_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 16;
  localparam int AVG_W     = 16;
  localparam int AGE_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // The average is sum * 16 / count, so the dividend is the sum magnitude
  // with four zero bits appended.
  localparam int FRAC_SHIFT = 4;
  localparam int DIVIDEND_W = SUM_W + FRAC_SHIFT;
  localparam int ITER_W     = $clog2(DIVIDEND_W + 1);

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_DISCONNECTED = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;
  localparam logic [1:0] ST_TIMEOUT      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sensor_missing;
  } in_word_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic [1:0]              status;
    logic                    accepted;
    logic                    valid_res;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/qualified_moving_average_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qualified_moving_average_core
// Temperature sample qualifier with a moving-average window and a tick-driven
// staleness timeout. The average is divided out one quotient bit per cycle.
// ----------------------------------------------------------------------------
// A tick or a rejected sample goes from S_IDLE to S_PUSH, then into the output register;
// an accepted sample passes the bit-serial restoring divider in S_DIV (one quotient bit
// per cycle), then S_SIGN and S_PUSH. A full output register adds its stall.
// Words are taken one at a time: in_ready is high only in S_IDLE, so a new word waits
// until the last result has been loaded into the output register.
// Synchronous active-low reset clears window, sum, counters and status; presets registers.
module qualified_moving_average_core #(
  parameter int FILTER_DEPTH = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire qma_pkg::in_word_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output qma_pkg::out_word_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [qma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qma_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import qma_pkg::*;

  localparam int SLOT_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FILTER_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FILTER_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(FILTER_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_PUSH} fsm_t;

  fsm_t                       fsm_r;
  logic signed [SAMPLE_W-1:0] ring_r [FILTER_DEPTH];
  logic signed [SUM_W-1:0]    sum_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [AVG_W-1:0]    last_avg_r;
  logic [1:0]                 status_r;
  logic [AGE_W-1:0]           age_r;
  logic                       acc_r;
  logic signed [SAMPLE_W-1:0] min_temp_r;
  logic signed [SAMPLE_W-1:0] max_temp_r;
  logic [AGE_W-1:0]           timeout_r;

  logic [DIVIDEND_W-1:0]      dq_r;
  logic [CNT_W-1:0]           rem_r;
  logic [CNT_W-1:0]           div_r;
  logic                       neg_r;
  logic [ITER_W-1:0]          iter_r;

  logic                       out_valid_r;
  out_word_t                  out_data_r;

  logic signed [SUM_W-1:0]    sum_nxt;
  logic [SLOT_W-1:0]          slot_nxt;
  logic [CNT_W-1:0]           cnt_nxt;
  logic [AGE_W-1:0]           age_nxt;
  logic [SUM_W-1:0]           mag;
  logic                       out_of_range;
  logic                       take;
  logic                       out_load;
  logic [CNT_W:0]             trial;
  logic                       qbit;
  logic [CNT_W-1:0]           rem_nxt;
  logic [DIVIDEND_W-1:0]      quot_signed;

  assign in_ready  = (fsm_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sum_nxt = sum_r
            - {{(SUM_W-SAMPLE_W){ring_r[slot_r][SAMPLE_W-1]}}, ring_r[slot_r]}
            + {{(SUM_W-SAMPLE_W){in_data.sample_value[SAMPLE_W-1]}},
               in_data.sample_value};
    slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
    cnt_nxt  = (cnt_r == FULL_CNT) ? cnt_r : cnt_r + 1'b1;
    age_nxt  = (age_r == '1) ? age_r : age_r + 1'b1;
    mag      = sum_nxt[SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;
    out_of_range = (in_data.sample_value < min_temp_r) ||
                   (in_data.sample_value > max_temp_r);
    take     = !in_data.mode && !in_data.sensor_missing && !out_of_range;
    out_load = (fsm_r == S_PUSH) && (!out_valid_r || out_ready);
    // Restoring division: bring down the next dividend bit and try the divisor.
    trial   = {rem_r, dq_r[DIVIDEND_W-1]};
    qbit    = (trial >= {1'b0, div_r});
    rem_nxt = qbit ? CNT_W'(trial - {1'b0, div_r}) : CNT_W'(trial);
    quot_signed = neg_r ? (~dq_r + 1'b1) : dq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      for (int i = 0; i < FILTER_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      sum_r       <= '0;
      slot_r      <= '0;
      cnt_r       <= '0;
      last_avg_r  <= '0;
      status_r    <= ST_OK;
      age_r       <= '0;
      acc_r       <= 1'b0;
      min_temp_r  <= 12'sd0;
      max_temp_r  <= 12'sd960;
      timeout_r   <= 16'd3000;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MIN_TEMP:      min_temp_r <= cfg_data[SAMPLE_W-1:0];
          CFG_MAX_TEMP:      max_temp_r <= cfg_data[SAMPLE_W-1:0];
          CFG_TIMEOUT_TICKS: timeout_r  <= cfg_data[AGE_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (fsm_r)
        S_IDLE: begin
          if (in_valid) begin
            acc_r <= take;
            fsm_r <= take ? S_DIV : S_PUSH;
            if (in_data.mode) begin
              age_r <= age_nxt;
              if (status_r == ST_OK && age_nxt > timeout_r) begin
                status_r <= ST_TIMEOUT;
              end
            end else if (in_data.sensor_missing) begin
              status_r <= ST_DISCONNECTED;
            end else if (out_of_range) begin
              status_r <= ST_OUT_OF_RANGE;
            end else begin
              ring_r[slot_r] <= in_data.sample_value;
              sum_r    <= sum_nxt;
              slot_r   <= slot_nxt;
              cnt_r    <= cnt_nxt;
              status_r <= ST_OK;
              age_r    <= '0;
              dq_r     <= {mag, {FRAC_SHIFT{1'b0}}};
              neg_r    <= sum_nxt[SUM_W-1];
              div_r    <= cnt_nxt;
              rem_r    <= '0;
              iter_r   <= '0;
            end
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          dq_r   <= {dq_r[DIVIDEND_W-2:0], qbit};
          iter_r <= iter_r + 1'b1;
          if (iter_r == ITER_W'(DIVIDEND_W - 1)) begin
            fsm_r <= S_SIGN;
          end
        end
        S_SIGN: begin
          last_avg_r <= quot_signed[AVG_W-1:0];
          fsm_r      <= S_PUSH;
        end
        S_PUSH: begin
          if (out_load) begin
            out_data_r.average   <= last_avg_r;
            out_data_r.status    <= status_r;
            out_data_r.accepted  <= acc_r;
            out_data_r.valid_res <= (status_r == ST_OK);
            fsm_r                <= S_IDLE;
          end
        end
        default: fsm_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for qualified_moving_average_core
// Drives sample and tick words with random gaps, stalls the result side at
// random, and checks every result word against a cycle-free model of the
// filter window, sensor status and staleness timer kept here. Registers are
// reprogrammed between phases, including the range extremes, an inverted
// range and a short timeout that a run of ticks trips.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qma_pkg::*;

  localparam int DEPTH = 10;
  // Index outside the register map; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  qualified_moving_average_core #(.FILTER_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Filter state as the block should hold it.
  int         win_ring [16];
  int         win_sum = 0;
  int         win_slot = 0;
  int         win_fill = 0;
  int         avg_hold = 0;
  logic [1:0] sensor_st = ST_OK;
  int         stale_age = 0;
  int         lim_lo = 0;
  int         lim_hi = 960;
  int         stale_limit = 3000;

  in_word_t  pending_words [$];
  out_word_t expected_results [$];

  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_taken = 0;
  int   n_ticks = 0;
  int   n_reg_writes = 0;
  int   n_settings = 0;
  int   mismatches = 0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  logic rx_hold = 1'b0;

  function automatic out_word_t filter_step(in_word_t w);
    out_word_t r;
    int        s;
    r.accepted = 1'b0;
    if (w.mode) begin
      n_ticks++;
      if (stale_age < 65535) stale_age++;
      if (sensor_st == ST_OK && stale_age > stale_limit) sensor_st = ST_TIMEOUT;
    end else begin
      s = $signed(w.sample_value);
      if (w.sensor_missing) begin
        sensor_st = ST_DISCONNECTED;
      end else if (s < lim_lo || s > lim_hi) begin
        sensor_st = ST_OUT_OF_RANGE;
      end else begin
        win_sum = win_sum - win_ring[win_slot] + s;
        win_ring[win_slot] = s;
        win_slot = (win_slot + 1 >= DEPTH) ? 0 : win_slot + 1;
        if (win_fill < DEPTH) win_fill++;
        // Integer division truncates toward zero, as the block must.
        avg_hold = (win_sum * 16) / win_fill;
        sensor_st = ST_OK;
        stale_age = 0;
        r.accepted = 1'b1;
        n_taken++;
      end
    end
    r.average = avg_hold[15:0];
    r.status = sensor_st;
    r.valid_res = (sensor_st == ST_OK);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic in_word_t make_word(logic m, int v, logic miss);
    in_word_t w;
    w.mode = m;
    w.sample_value = v[11:0];
    w.sensor_missing = miss;
    return w;
  endfunction

  // Mostly in-range samples so the window keeps moving; the rest are ticks,
  // missing sensors and samples anywhere in the field's range.
  function automatic in_word_t rand_word(int lo, int hi);
    int r;
    int v;
    r = $urandom_range(0, 99);
    v = int'($urandom_range(0, 4095)) - 2048;
    if (r >= 30 && lo <= hi) v = lo + int'($urandom_range(0, hi - lo));
    return make_word(r < 15, v, r >= 15 && r < 22);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 20) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic queue_word(input in_word_t w);
    pending_words.push_back(w);
    n_queued++;
  endtask

  // Called at a rising edge; leaves cfg_valid high so back-to-back writes
  // never lower and raise it in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_TEMP:      lim_lo = $signed(val[11:0]);
      CFG_MAX_TEMP:      lim_hi = $signed(val[11:0]);
      CFG_TIMEOUT_TICKS: stale_limit = val;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0) @(posedge clk);
    // Allow for the longest path through the block, an accepted sample through the divider.
    repeat (30) @(posedge clk);
  endtask

  // Input side.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(filter_step(in_data));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (tx_idle_en) tx_wait = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data.average !== want.average)
            report_mismatch($sformatf("average %0d, expected %0d",
                                      $signed(out_data.average), $signed(want.average)));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %0b, expected %0b",
                                      out_data.accepted, want.accepted));
          if (out_data.valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res %0b, expected %0b",
                                      out_data.valid_res, want.valid_res));
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        rx_wait = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int a;
    int b;
    int lo;
    int hi;
    int tmo;
    foreach (win_ring[i]) win_ring[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: range 0..960, timeout 3000.
    queue_word(make_word(1'b1, 0, 1'b0));
    queue_word(make_word(1'b0, 5, 1'b1));
    queue_word(make_word(1'b1, 0, 1'b0));      // tick leaves disconnected alone
    queue_word(make_word(1'b0, 960, 1'b0));
    queue_word(make_word(1'b0, 0, 1'b0));
    queue_word(make_word(1'b0, 961, 1'b0));
    queue_word(make_word(1'b0, -1, 1'b0));
    queue_word(make_word(1'b0, 2047, 1'b1));   // missing wins over out of range
    queue_word(make_word(1'b0, -2048, 1'b0));
    wait_drained();

    // Full range, written with junk in the upper data bits, and zero timeout.
    write_reg(CFG_MIN_TEMP, 16'hF800);
    write_reg(CFG_MAX_TEMP, 16'hA7FF);
    write_reg(CFG_TIMEOUT_TICKS, 16'd0);
    write_reg(CFG_SPARE, 16'h0123);
    end_writes();
    queue_word(make_word(1'b0, -2048, 1'b0));
    queue_word(make_word(1'b0, 2047, 1'b0));
    queue_word(make_word(1'b1, 0, 1'b0));
    queue_word(make_word(1'b1, 0, 1'b0));
    for (int i = 0; i < 10; i++) begin
      queue_word(make_word(1'b0, (i % 2) ? 2047 : -2048, 1'b0));
    end
    wait_drained();

    // Inverted range: every present sample is rejected.
    write_reg(CFG_MIN_TEMP, 16'd100);
    write_reg(CFG_MAX_TEMP, 16'hFF9C);
    write_reg(CFG_TIMEOUT_TICKS, 16'd1);
    end_writes();
    queue_word(make_word(1'b0, 0, 1'b0));
    queue_word(make_word(1'b0, 0, 1'b1));
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      a = int'($urandom_range(0, 4095)) - 2048;
      b = int'($urandom_range(0, 4095)) - 2048;
      case ($urandom_range(0, 4))
        0: begin
          lo = -2048;
          hi = 2047;
        end
        1: begin
          lo = (a > b) ? a : b;
          hi = (a > b) ? b : a;
        end
        default: begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
      endcase
      case ($urandom_range(0, 3))
        0: tmo = 0;
        1: tmo = $urandom_range(1, 8);
        2: tmo = $urandom_range(9, 40);
        default: tmo = 65535;
      endcase
      write_reg(CFG_MIN_TEMP, {4'($urandom), lo[11:0]});
      write_reg(CFG_MAX_TEMP, {4'($urandom), hi[11:0]});
      write_reg(CFG_TIMEOUT_TICKS, tmo[15:0]);
      if (p == 2) write_reg(CFG_SPARE, 16'($urandom));
      end_writes();

      if (p == 0) begin
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
      end else if (p == 3) begin
        // Receiver holds off while the sender keeps offering words.
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b1;
        fork
          begin
            rx_hold <= 1'b1;
            repeat (400) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end else begin
        tx_idle_en <= ($urandom_range(0, 3) != 0);
        rx_idle_en <= ($urandom_range(0, 3) != 0);
      end
      for (int i = 0; i < 220; i++) queue_word(rand_word(lo, hi));
      wait_drained();
    end

    // Staleness timer: a good sample, then a run of ticks past a short timeout.
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    write_reg(CFG_MIN_TEMP, 16'h0800);
    write_reg(CFG_MAX_TEMP, 16'h07FF);
    write_reg(CFG_TIMEOUT_TICKS, 16'd20);
    end_writes();
    queue_word(make_word(1'b0, 321, 1'b0));
    for (int i = 0; i < 25; i++) queue_word(make_word(1'b1, i, i[2]));
    queue_word(make_word(1'b0, -321, 1'b0));
    wait_drained();

    $display("Checked %0d result words: %0d samples entered the window, %0d ticks.",
             n_checked, n_taken, n_ticks);
    $display("Made %0d register writes over %0d settings: range extremes, an inverted range,",
             n_reg_writes, n_settings);
    $display("zero, short and maximum timeouts, and a long receiver stall.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/qma_pkg.sv
hdl/qualified_moving_average_core.sv
tb/testbench.sv
